[rtl/core/gscan_pkg.sv]
// Package for the Graham scan convex hull unit.
// Holds the size constants used by the RTL; no dependencies.
package gscan_pkg;

  localparam int unsigned MaxPointsDef = 64;
  localparam int unsigned CoordBitsDef = 16;
  localparam int unsigned MinHull      = 3;

endpackage

[rtl/core/graham_scan_convex_hull_unit.sv]
// Graham scan convex hull unit: top level. Uses gscan_pkg and gscan_mem.
// Points are taken one per cycle while a set loads; a set of fewer than three points is
// discarded. On the final point of a larger set the unit searches for the pivot, sorts the
// points by angle with an insertion sort, runs the scan and then sends out the hull vertices,
// which the receiver can stall; no point is accepted meanwhile.
// State, load count, drop flag, output valid and stack pointer clear on async reset.
module graham_scan_convex_hull_unit
  import gscan_pkg::*;
#(
  parameter int unsigned MaxPoints = MaxPointsDef,
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  logic [CoordBits-1:0] px_i,
  input  logic [CoordBits-1:0] py_i,
  input  logic                 final_point_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output logic [CoordBits-1:0] hx_o,
  output logic [CoordBits-1:0] hy_o,
  output logic                 final_vertex_o,
  output logic                 dropped_o
);
  localparam int unsigned AW = $clog2(MaxPoints);
  localparam int unsigned CW = $clog2(MaxPoints + 1);
  localparam int unsigned PW = 2 * CoordBits;
  localparam int unsigned DW = CoordBits + 2;       // difference width
  localparam int unsigned XW = 2 * DW + 2;          // product/sum width

  localparam logic [3:0] S_LOAD = 4'd0, S_PIV = 4'd1, S_PIVW = 4'd2, S_SWAP = 4'd3,
                         S_SRD = 4'd4, S_SCMP = 4'd5, S_SRD2 = 4'd6, S_SCAND = 4'd7,
                         S_CRD = 4'd8, S_CCMP = 4'd9, S_CPOP = 4'd10, S_OUT = 4'd11,
                         S_ORD = 4'd12, S_SWP2 = 4'd13;

  logic [3:0] st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d, n_q, n_d, i_q, i_d, j_q, j_d, sp_q, sp_d;
  logic ovf_q, ovf_d;
  logic [PW-1:0] piv_q, piv_d, t_q, t_d, cand_q, cand_d, top_q, top_d, best_q, best_d;
  logic [CW-1:0] bi_q, bi_d;
  logic ov_q, ov_d, ofin_q, ofin_d, odrop_q, odrop_d;
  logic [PW-1:0] odat_q, odat_d;

  // point memory
  logic pwe; logic [AW-1:0] pwa, pra; logic [PW-1:0] pwd, prd;
  // stack memory
  logic swe; logic [AW-1:0] swa, sra; logic [PW-1:0] swd, srd;

  gscan_mem #(.Depth(MaxPoints), .Width(PW)) u_pts (
    .clk_i, .we_i(pwe), .waddr_i(pwa), .wdata_i(pwd), .raddr_i(pra), .rdata_o(prd));
  gscan_mem #(.Depth(MaxPoints), .Width(PW)) u_stk (
    .clk_i, .we_i(swe), .waddr_i(swa), .wdata_i(swd), .raddr_i(sra), .rdata_o(srd));

  function automatic logic signed [DW-1:0] dif(input logic [CoordBits-1:0] a,
                                                input logic [CoordBits-1:0] b);
    return DW'(signed'(a)) - DW'(signed'(b));
  endfunction
  function automatic logic [CoordBits-1:0] gx(input logic [PW-1:0] p);
    return p[CoordBits-1:0];
  endfunction
  function automatic logic [CoordBits-1:0] gy(input logic [PW-1:0] p);
    return p[PW-1:CoordBits];
  endfunction

  // angle_before(a=t, b=prd, p=piv)
  logic signed [DW-1:0] ax, ay, bx, by;
  logic signed [XW-1:0] cr, da, db;
  logic az, bz, ang_lt;
  always_comb begin
    ax = dif(gx(t_q), gx(piv_q));  ay = dif(gy(t_q), gy(piv_q));
    bx = dif(gx(prd), gx(piv_q));  by = dif(gy(prd), gy(piv_q));
    az = (ax == '0) && (ay == '0);
    bz = (bx == '0) && (by == '0);
    cr = XW'(ax) * XW'(by) - XW'(ay) * XW'(bx);
    da = XW'(ax) * XW'(ax) + XW'(ay) * XW'(ay);
    db = XW'(bx) * XW'(bx) + XW'(by) * XW'(by);
    if (az) ang_lt = !bz;
    else if (bz) ang_lt = 1'b0;
    else if (cr > 0) ang_lt = 1'b1;
    else if (cr < 0) ang_lt = 1'b0;
    else ang_lt = da < db;
  end

  // keep_turn(p0=top, p1=cand, p2=nxt=prd)
  logic signed [DW-1:0] ux, uy, vx, vy, wx, wy;
  logic signed [XW-1:0] kc, d1, d2;
  logic keep;
  always_comb begin
    ux = dif(gx(cand_q), gx(top_q)); uy = dif(gy(cand_q), gy(top_q));
    vx = dif(gx(prd), gx(cand_q));   vy = dif(gy(prd), gy(cand_q));
    wx = dif(gx(prd), gx(top_q));    wy = dif(gy(prd), gy(top_q));
    kc = XW'(ux) * XW'(vy) - XW'(uy) * XW'(vx);
    d1 = XW'(ux) * XW'(ux) + XW'(uy) * XW'(uy);
    d2 = XW'(wx) * XW'(wx) + XW'(wy) * XW'(wy);
    keep = (kc > 0) || ((kc == 0) && (d1 > d2));
  end

  logic acc;
  assign stall_o = (st_q != S_LOAD);
  assign acc = valid_i && !stall_o;
  assign valid_o = ov_q;
  assign hx_o = gx(odat_q);
  assign hy_o = gy(odat_q);
  assign final_vertex_o = ofin_q;
  assign dropped_o = odrop_q;

  logic [CW-1:0] nxt_idx;
  assign nxt_idx = (i_q == n_q) ? '0 : i_q;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; n_d = n_q; i_d = i_q; j_d = j_q; sp_d = sp_q;
    ovf_d = ovf_q; piv_d = piv_q; t_d = t_q; cand_d = cand_q; top_d = top_q;
    best_d = best_q; bi_d = bi_q; ov_d = ov_q; ofin_d = ofin_q;
    odrop_d = odrop_q; odat_d = odat_q;
    pwe = 1'b0; pwa = '0; pwd = '0; pra = '0;
    swe = 1'b0; swa = '0; swd = '0; sra = '0;
    case (st_q)
      S_LOAD: begin
        if (acc) begin
          if (cnt_q < CW'(MaxPoints)) begin
            pwe = 1'b1; pwa = AW'(cnt_q); pwd = {py_i, px_i};
          end else ovf_d = 1'b1;
          if (final_point_i) begin
            n_d = (cnt_q < CW'(MaxPoints)) ? cnt_q + 1'b1 : cnt_q;
            cnt_d = '0;
            if (n_d < CW'(MinHull)) ovf_d = 1'b0;
            else begin
              st_d = S_PIVW; i_d = '0; bi_d = '0;
            end
          end else if (cnt_q < CW'(MaxPoints)) cnt_d = cnt_q + 1'b1;
        end
      end
      S_PIVW: begin // issue read of i
        pra = AW'(i_q); st_d = S_PIV;
      end
      S_PIV: begin
        if (i_q == '0 || signed'(gy(prd)) < signed'(gy(best_q)) ||
            (gy(prd) == gy(best_q) && signed'(gx(prd)) < signed'(gx(best_q)))) begin
          best_d = prd; bi_d = i_q;
        end
        if (i_q == n_q - 1'b1) begin
          pra = '0; st_d = S_SWAP;
        end else begin
          i_d = i_q + 1'b1; st_d = S_PIVW;
        end
      end
      S_SWAP: begin // prd = point 0
        pwe = 1'b1; pwa = AW'(bi_q); pwd = prd;
        st_d = S_SWP2;
      end
      S_SWP2: begin
        pwe = 1'b1; pwa = '0; pwd = best_q; piv_d = best_q;
        i_d = CW'(2); st_d = S_SRD;
      end
      S_SRD: begin // fetch t = point i
        if (i_q >= n_q) begin
          st_d = S_SCAND; pra = '0;
        end else begin
          pra = AW'(i_q); st_d = S_SRD2; j_d = i_q;
        end
      end
      S_SRD2: begin
        t_d = prd; pra = AW'(j_q - 1'b1); st_d = S_SCMP;
      end
      S_SCMP: begin // prd = point j-1; at j == 1 the test fails and t lands at 1
        if (j_q > CW'(1) && ang_lt) begin
          pwe = 1'b1; pwa = AW'(j_q); pwd = prd;
          j_d = j_q - 1'b1; pra = AW'(j_q - 2'd2);
          st_d = S_SCMP;
        end else begin
          pwe = 1'b1; pwa = AW'(j_q); pwd = t_q;
          i_d = i_q + 1'b1; st_d = S_SRD;
        end
      end
      S_SCAND: begin // prd = point 0 (pivot); read point 1
        swe = 1'b1; swa = '0; swd = piv_q; sp_d = CW'(1); top_d = piv_q;
        pra = AW'(1); i_d = CW'(2); st_d = S_CRD;
      end
      S_CRD: begin // prd = point 1 -> cand; read nxt
        cand_d = prd; pra = AW'(nxt_idx); st_d = S_CCMP;
      end
      S_CCMP: begin // prd = nxt
        if (sp_q < CW'(2) || keep) begin
          if (sp_q < CW'(MaxPoints)) begin
            swe = 1'b1; swa = AW'(sp_q); swd = cand_q; sp_d = sp_q + 1'b1;
            top_d = cand_q;
          end
          cand_d = prd; i_d = i_q + 1'b1;
          if (i_q + 1'b1 > n_q) begin
            st_d = S_ORD; j_d = '0;
          end else begin
            pra = AW'((i_q + 1'b1 == n_q) ? '0 : i_q + 1'b1); st_d = S_CCMP;
          end
        end else begin
          sp_d = sp_q - 1'b1; cand_d = top_q;
          sra = AW'(sp_q - 2'd2); st_d = S_CPOP;
        end
      end
      S_CPOP: begin // srd = new top
        top_d = srd; pra = AW'(nxt_idx); st_d = S_CCMP;
      end
      S_ORD: begin
        if (!ov_q || !stall_i) begin
          sra = AW'(j_q); st_d = S_OUT;
        end
      end
      S_OUT: begin
        ov_d = 1'b1; odat_d = srd; ofin_d = (j_q + 1'b1 == sp_q);
        odrop_d = ovf_q;
        j_d = j_q + 1'b1;
        if (j_q + 1'b1 == sp_q) begin
          // the set is done; the next one starts with a clean drop flag
          st_d = S_LOAD; ovf_d = 1'b0;
        end else st_d = S_ORD;
      end
      default: st_d = S_LOAD;
    endcase
    if (ov_q && !stall_i && !(st_q == S_OUT)) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_LOAD; cnt_q <= '0; ovf_q <= 1'b0; ov_q <= 1'b0; sp_q <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; ovf_q <= ovf_d; ov_q <= ov_d; sp_q <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; i_q <= i_d; j_q <= j_d; piv_q <= piv_d; t_q <= t_d;
    cand_q <= cand_d; top_q <= top_d; best_q <= best_d; bi_q <= bi_d;
    ofin_q <= ofin_d; odrop_q <= odrop_d; odat_q <= odat_d;
  end
endmodule

[rtl/core/gscan_mem.sv]
// Point memory and hull stack memory of the Graham scan unit.
// Simple dual-port style: one write and one registered read per cycle each.
module gscan_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
